FILE: src/utf8dw_pkg.sv
// Shared types, constants and the column width table of the UTF-8 width meter.
`default_nettype none

package utf8dw_pkg;

    localparam int CP_BITS = 21;

    localparam logic [CP_BITS-1:0] REPL_CP   = 21'h00FFFD;
    localparam logic [CP_BITS-1:0] MAX_CP    = 21'h10FFFF;
    localparam logic [CP_BITS-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_BITS-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CP_BITS-1:0] MIN_CP_2  = 21'h000080;
    localparam logic [CP_BITS-1:0] MIN_CP_3  = 21'h000800;
    localparam logic [CP_BITS-1:0] MIN_CP_4  = 21'h010000;

    // Buffered sequence: lead plus good continuations seen so far.
    typedef struct packed {
        logic [1:0]         cnt;
        logic [2:0]         len;
        logic [CP_BITS-1:0] cp;
    } pend_t;

    // What one input byte produces: a run of one-byte replacements, then an
    // optional tail result, and the sequence left buffered afterwards.
    typedef struct packed {
        logic [2:0]         repl_cnt;
        logic               tail_valid;
        logic [CP_BITS-1:0] tail_cp;
        logic [2:0]         tail_bytes;
        logic               tail_repl;
        pend_t              pend;
    } plan_t;

    typedef struct packed {
        logic [CP_BITS-1:0] lo;
        logic [CP_BITS-1:0] hi;
        logic [1:0]         w;
    } span_t;

    localparam int NUM_SPANS = 21;

    // First matching span wins; zero-width spans come first.
    localparam span_t WIDTH_SPANS [NUM_SPANS] = '{
        '{21'h000000, 21'h00001F, 2'd0}, '{21'h00007F, 21'h00009F, 2'd0},
        '{21'h000300, 21'h00036F, 2'd0}, '{21'h001AB0, 21'h001AFF, 2'd0},
        '{21'h001DC0, 21'h001DFF, 2'd0}, '{21'h0020D0, 21'h0020FF, 2'd0},
        '{21'h00FE20, 21'h00FE2F, 2'd0}, '{21'h00200B, 21'h00200D, 2'd0},
        '{21'h002060, 21'h002060, 2'd0}, '{21'h00FEFF, 21'h00FEFF, 2'd0},
        '{21'h002E80, 21'h002FDF, 2'd2}, '{21'h002FF0, 21'h00A4CF, 2'd2},
        '{21'h00A960, 21'h00A97F, 2'd2}, '{21'h00AC00, 21'h00D7FF, 2'd2},
        '{21'h00F900, 21'h00FAFF, 2'd2}, '{21'h00FE10, 21'h00FE1F, 2'd2},
        '{21'h00FE30, 21'h00FE6F, 2'd2}, '{21'h00FF00, 21'h00FF60, 2'd2},
        '{21'h00FFE0, 21'h00FFE6, 2'd2}, '{21'h020000, 21'h03FFFF, 2'd2},
        '{21'h01F300, 21'h01FBFF, 2'd2}
    };

    function automatic logic [1:0] col_width(input logic [CP_BITS-1:0] cp);
        logic [1:0] w;
        logic       hit;
        w   = 2'd1;
        hit = 1'b0;
        for (int i = 0; i < NUM_SPANS; i++)
        begin
            if (!hit && cp >= WIDTH_SPANS[i].lo && cp <= WIDTH_SPANS[i].hi)
            begin
                w   = WIDTH_SPANS[i].w;
                hit = 1'b1;
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: src/utf8dw_decode.sv
// Byte decoder: turns one byte and the buffered sequence into a result plan.
`default_nettype none

module utf8dw_decode (
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  utf8dw_pkg::pend_t      pend,
    output utf8dw_pkg::plan_t      plan
);
    import utf8dw_pkg::*;

    logic [2:0]         blen;
    logic [CP_BITS-1:0] bbits;
    logic               b_cont;
    logic [CP_BITS-1:0] full_cp;
    logic [2:0]         filled;
    logic               bad_value;
    plan_t              lead_plan;

    // Classify the byte as a lead
    always_comb
    begin
        b_cont = (data_byte[7:6] == 2'b10);
        if (data_byte[7] == 1'b0)
        begin
            blen  = 3'd1;
            bbits = CP_BITS'(data_byte);
        end
        else if (data_byte[7:5] == 3'b110)
        begin
            blen  = 3'd2;
            bbits = CP_BITS'(data_byte[4:0]);
        end
        else if (data_byte[7:4] == 4'b1110)
        begin
            blen  = 3'd3;
            bbits = CP_BITS'(data_byte[3:0]);
        end
        else if (data_byte[7:3] == 5'b11110)
        begin
            blen  = 3'd4;
            bbits = CP_BITS'(data_byte[2:0]);
        end
        else
        begin
            blen  = 3'd0;
            bbits = '0;
        end
    end

    // Plan for the byte taken as a fresh lead
    always_comb
    begin
        lead_plan            = '0;
        lead_plan.tail_bytes = 3'd1;
        if (blen == 3'd0)
        begin
            lead_plan.tail_valid = 1'b1;
            lead_plan.tail_cp    = REPL_CP;
            lead_plan.tail_repl  = 1'b1;
        end
        else if (blen == 3'd1)
        begin
            lead_plan.tail_valid = 1'b1;
            lead_plan.tail_cp    = bbits;
        end
        else if (last_byte)
        begin
            lead_plan.tail_valid = 1'b1;
            lead_plan.tail_cp    = REPL_CP;
            lead_plan.tail_repl  = 1'b1;
        end
        else
        begin
            lead_plan.pend.cnt = 2'd1;
            lead_plan.pend.len = blen;
            lead_plan.pend.cp  = bbits;
        end
    end

    // Extend the buffered sequence by a continuation and check the value
    always_comb
    begin
        full_cp   = {pend.cp[CP_BITS-7:0], data_byte[5:0]};
        filled    = 3'(pend.cnt) + 3'd1;
        bad_value = (pend.len == 3'd2 && full_cp < MIN_CP_2) ||
                    (pend.len == 3'd3 && full_cp < MIN_CP_3) ||
                    (pend.len == 3'd4 && full_cp < MIN_CP_4) ||
                    (full_cp >= SURR_LO && full_cp <= SURR_HI) ||
                    (full_cp > MAX_CP);
    end

    // Pick the plan
    always_comb
    begin
        plan = '0;
        if (pend.cnt == 2'd0)
        begin
            plan = lead_plan;
        end
        else if (!b_cont)
        begin
            // lead and buffered continuations fall out, then replay the byte
            plan          = lead_plan;
            plan.repl_cnt = 3'(pend.cnt);
        end
        else if (filled == pend.len)
        begin
            plan.tail_valid = 1'b1;
            plan.tail_cp    = bad_value ? REPL_CP : full_cp;
            plan.tail_bytes = pend.len;
            plan.tail_repl  = bad_value;
        end
        else if (last_byte)
        begin
            plan.repl_cnt = filled;
        end
        else
        begin
            plan.pend.cnt = filled[1:0];
            plan.pend.len = pend.len;
            plan.pend.cp  = full_cp;
        end
    end

endmodule

`default_nettype wire

FILE: src/utf8_display_width_meter_top.sv
// Top level of the UTF-8 display width meter: input stage, result sequencer, output register.
`default_nettype none

// Bytes are registered in the input stage, their results in the output register.
// Throughput: one byte per cycle while each byte yields at most one result and the
// output is not stalled; a byte with up to four results holds the input stage until
// its last result is taken, as the output register takes one result per cycle.
// Reset clears the stage valid flags, the buffered sequence and the running total.
module utf8_display_width_meter_top #(
    parameter int TOTAL_WIDTH_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [20:0] code_point, [22:21] column_width,
                                        // [25:23] bytes_used, [57:26] total_width, rest 0
    output logic             m_tuser,   // is_replacement
    output logic             m_tlast    // string_end
);
    import utf8dw_pkg::*;

    // input stage
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    // sequence and total state
    pend_t                       pend_reg, pend_next;
    logic [2:0]                  rep_done_reg, rep_done_next;
    logic [TOTAL_WIDTH_BITS-1:0] sum_reg, sum_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [CP_BITS-1:0] out_cp_reg;
    logic [1:0]         out_w_reg;
    logic [2:0]         out_bytes_reg;
    logic               out_repl_reg;
    logic [31:0]        out_total_reg;
    logic               out_end_reg;

    plan_t              plan;
    logic               out_free;
    logic               have_repl;
    logic               emit_any;
    logic               emit_fire;
    logic               final_emit;
    logic               item_done;
    logic [CP_BITS-1:0] emit_cp;
    logic [2:0]         emit_bytes;
    logic               emit_repl;
    logic [1:0]         emit_w;
    logic               emit_end;
    logic [TOTAL_WIDTH_BITS:0]   sum_add;
    logic [TOTAL_WIDTH_BITS-1:0] sum_sat;
    logic [63:0]                 sum_wide;

    utf8dw_decode u_decode (
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .pend      (pend_reg),
        .plan      (plan)
    );

    // Sequence the results of the byte in the input stage
    always_comb
    begin
        out_free   = !out_valid_reg || m_tready;
        have_repl  = rep_done_reg < plan.repl_cnt;
        emit_any   = s1_valid_reg && (have_repl || plan.tail_valid);
        emit_fire  = emit_any && out_free;
        final_emit = have_repl ? ((rep_done_reg + 3'd1 == plan.repl_cnt) && !plan.tail_valid)
                               : 1'b1;
        item_done  = s1_valid_reg && (emit_any ? (emit_fire && final_emit) : 1'b1);
        s_tready   = !s1_valid_reg || item_done;
    end

    // Form the result and the saturating total
    always_comb
    begin
        emit_cp    = have_repl ? REPL_CP : plan.tail_cp;
        emit_bytes = have_repl ? 3'd1 : plan.tail_bytes;
        emit_repl  = have_repl ? 1'b1 : plan.tail_repl;
        emit_w     = col_width(emit_cp);
        emit_end   = s1_last_reg && final_emit;
        sum_add    = {1'b0, sum_reg} + (TOTAL_WIDTH_BITS + 1)'(emit_w);
        sum_sat    = sum_add[TOTAL_WIDTH_BITS] ? '1 : sum_add[TOTAL_WIDTH_BITS-1:0];
        sum_wide   = 64'(sum_sat);
    end

    // Next state of control
    always_comb
    begin
        s1_valid_next  = s_tready ? s_tvalid : s1_valid_reg;
        out_valid_next = emit_fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

        rep_done_next = rep_done_reg;
        if (item_done)
            rep_done_next = 3'd0;
        else if (emit_fire && have_repl)
            rep_done_next = rep_done_reg + 3'd1;

        pend_next = pend_reg;
        if (item_done)
            pend_next = s1_last_reg ? '0 : plan.pend;

        sum_next = sum_reg;
        if (emit_fire)
            sum_next = emit_end ? '0 : sum_sat;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rep_done_reg  <= 3'd0;
            pend_reg      <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            rep_done_reg  <= rep_done_next;
            pend_reg      <= pend_next;
            sum_reg       <= sum_next;
        end
    end

    // Capture the input beat and the result beat
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_byte_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        if (emit_fire)
        begin
            out_cp_reg    <= emit_cp;
            out_w_reg     <= emit_w;
            out_bytes_reg <= emit_bytes;
            out_repl_reg  <= emit_repl;
            out_total_reg <= sum_wide[31:0];
            out_end_reg   <= emit_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_total_reg, out_bytes_reg, out_w_reg, out_cp_reg};
    assign m_tuser  = out_repl_reg;
    assign m_tlast  = out_end_reg;

    // A replay count is only in progress while a byte sits in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        rep_done_reg != 3'd0 |-> s1_valid_reg)
        else $error("replay count set with empty input stage");

    // A buffered sequence is always shorter than its lead announces
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg.cnt != 2'd0 |-> pend_reg.len > 3'(pend_reg.cnt))
        else $error("buffered sequence not shorter than its length");

    // The running total restarts after the final result of a string
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && emit_end |=> sum_reg == '0)
        else $error("running total not cleared at end of string");

    // A finished byte leaves the replay count at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        item_done |=> rep_done_reg == 3'd0)
        else $error("replay count not cleared after byte");

endmodule

`default_nettype wire
